// File: rtl/rvl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rvl_pkg
// Shared types and constants of the residual vibration level block.
// ----------------------------------------------------------------------------
package rvl_pkg;

    localparam int RATIO_W    = 20;
    localparam int HALF_W     = 4;
    localparam int LEN_W      = 13;
    localparam int LEVEL_W    = 30;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] REG_RATIO = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HALF  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEN   = 2'd2;

    localparam logic [RATIO_W-1:0] RATIO_RST = 20'd0;
    localparam logic [HALF_W-1:0]  HALF_RST  = 4'd5;
    localparam logic [LEN_W-1:0]   LEN_RST   = 13'd4096;

    typedef enum logic [1:0] {
        S_ACCUM,
        S_FLUSH,
        S_ROOT,
        S_EMIT
    } t_rvl_state;

    typedef struct packed {
        logic take;
        logic load_root;
        logic step_root;
        logic emit;
    } t_rvl_cmd;

    typedef struct packed {
        logic in_valid;
        logic in_last;
        logic pipe_empty;
        logic root_done;
        logic out_free;
    } t_rvl_sts;

endpackage
`default_nettype wire

// File: rtl/rvl_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rvl_if
// Channel interfaces: spectrum bin input, level output, register writes.
// ----------------------------------------------------------------------------
interface rvl_bin_if #(parameter int SAMPLE_BITS = 24) ();
    logic                          valid;
    logic                          ready;
    logic signed [SAMPLE_BITS-1:0] bin_amplitude;

    modport source (output valid, output bin_amplitude, input ready);
    modport sink   (input valid, input bin_amplitude, output ready);
endinterface

interface rvl_level_if import rvl_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [LEVEL_W-1:0] residual_level;

    modport source (output valid, output residual_level, input ready);
    modport sink   (input valid, input residual_level, output ready);
endinterface

interface rvl_cfg_if import rvl_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// File: rtl/rvl_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rvl_ctrl
// Sequencer: accumulate bins, drain the square pipeline, run the root, emit.
// ----------------------------------------------------------------------------
module rvl_ctrl import rvl_pkg::*; (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_rvl_sts i_sts,
    output t_rvl_cmd      o_cmd
);

    t_rvl_state r_state;
    t_rvl_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_ACCUM;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_ACCUM: begin
                if (i_sts.in_valid && i_sts.in_last) begin
                    n_state = S_FLUSH;
                end
            end
            S_FLUSH: begin
                if (i_sts.pipe_empty) begin
                    n_state = S_ROOT;
                end
            end
            S_ROOT: begin
                if (i_sts.root_done) begin
                    n_state = S_EMIT;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    n_state = S_ACCUM;
                end
            end
            default: n_state = S_ACCUM;
        endcase
    end

    always_comb begin
        o_cmd = '0;
        case (r_state)
            S_ACCUM: o_cmd.take      = 1'b1;
            S_FLUSH: o_cmd.load_root = i_sts.pipe_empty;
            S_ROOT:  o_cmd.step_root = !i_sts.root_done;
            S_EMIT:  o_cmd.emit      = i_sts.out_free;
            default: o_cmd = '0;
        endcase
    end

endmodule
`default_nettype wire

// File: rtl/rvl_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rvl_datapath
// Registers, harmonic masking, square accumulation, bit-pair square root
// and the output register.
// ----------------------------------------------------------------------------
module rvl_datapath import rvl_pkg::*; #(
    parameter int MAX_BINS    = 4096,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]          i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0]         i_cfg_data,
    output logic                               o_cfg_ready,
    input  wire logic                          i_bin_valid,
    input  wire logic signed [SAMPLE_BITS-1:0] i_bin_amplitude,
    output logic                               o_bin_ready,
    output logic                               o_level_valid,
    input  wire logic                          i_level_ready,
    output logic [LEVEL_W-1:0]                 o_residual_level,
    input  wire t_rvl_cmd                      i_cmd,
    output t_rvl_sts                           o_sts
);

    localparam int IDX_W   = $clog2(MAX_BINS);
    localparam int CMP_W   = ((IDX_W + 2) > 15) ? (IDX_W + 2) : 15;
    localparam int FULL_W  = 2 * SAMPLE_BITS - 1 + IDX_W;
    localparam int SUM_W   = (FULL_W > 64) ? 64 : FULL_W;
    localparam int RES_W   = (SUM_W + 1) / 2;
    localparam int SQ_W    = 2 * RES_W;
    localparam int N_CTR   = 4;

    logic [RATIO_W-1:0]       r_ratio;
    logic [HALF_W-1:0]        r_half;
    logic [LEN_W-1:0]         r_len;
    logic [IDX_W-1:0]         r_index;
    logic [SAMPLE_BITS-1:0]   r_mag;
    logic                     r_mag_vld;
    logic [2*SAMPLE_BITS-1:0] r_sq;
    logic                     r_sq_vld;
    logic [SUM_W-1:0]         r_sum;
    logic [SUM_W-1:0]         n_sum;
    logic [SQ_W-1:0]          r_x;
    logic [SQ_W-1:0]          r_res;
    logic [SQ_W-1:0]          r_bit;
    logic [LEVEL_W-1:0]       r_level;
    logic                     r_out_vld;

    logic [CMP_W-1:0]       w_len_eff;
    logic [CMP_W-1:0]       w_idx;
    logic [RATIO_W+1:0]     w_ratio3;
    logic [CMP_W-1:0]       w_ctr [N_CTR];
    logic [N_CTR-1:0]       w_near;
    logic                   w_last;
    logic                   w_take;
    logic [SAMPLE_BITS-1:0] w_raw;
    logic [SAMPLE_BITS-1:0] w_mag;
    logic [SUM_W:0]         w_sum_ext;
    logic [SQ_W-1:0]        w_trial;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio <= RATIO_RST;
            r_half  <= HALF_RST;
            r_len   <= LEN_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                REG_RATIO: r_ratio <= i_cfg_data[RATIO_W-1:0];
                REG_HALF:  r_half  <= i_cfg_data[HALF_W-1:0];
                REG_LEN:   r_len   <= i_cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        w_len_eff = CMP_W'(r_len);
        if (r_len == '0) begin
            w_len_eff = CMP_W'(1);
        end else if (w_len_eff > CMP_W'(MAX_BINS)) begin
            w_len_eff = CMP_W'(MAX_BINS);
        end
    end

    assign w_idx    = CMP_W'(r_index);
    assign w_ratio3 = (RATIO_W+2)'(r_ratio) + (RATIO_W+2)'({r_ratio, 1'b0});
    assign w_ctr[0] = CMP_W'(r_ratio >> 9);
    assign w_ctr[1] = CMP_W'(r_ratio >> 8);
    assign w_ctr[2] = CMP_W'({r_ratio, 1'b0} >> 8);
    assign w_ctr[3] = CMP_W'(w_ratio3 >> 8);

    for (genvar k = 0; k < N_CTR; k++) begin : g_near
        logic [CMP_W-1:0] w_dist;
        assign w_dist = (w_idx >= w_ctr[k]) ? (w_idx - w_ctr[k]) : (w_ctr[k] - w_idx);
        assign w_near[k] = (w_ctr[k] < w_len_eff) && (w_dist <= CMP_W'(r_half));
    end

    assign w_last = (w_idx + CMP_W'(1)) >= w_len_eff;
    assign w_take = i_cmd.take && i_bin_valid;
    assign w_raw  = i_bin_amplitude;
    assign w_mag  = w_raw[SAMPLE_BITS-1] ? (~w_raw + 1'b1) : w_raw;

    assign o_bin_ready = i_cmd.take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index   <= '0;
            r_mag_vld <= 1'b0;
            r_sq_vld  <= 1'b0;
        end else begin
            if (w_take) begin
                r_index <= w_last ? '0 : r_index + 1'b1;
            end
            r_mag_vld <= w_take;
            r_sq_vld  <= r_mag_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mag <= (|w_near) ? '0 : w_mag;
        r_sq  <= r_mag * r_mag;
    end

    assign w_sum_ext = {1'b0, r_sum} + (SUM_W+1)'(r_sq);

    always_comb begin
        n_sum = r_sum;
        if (i_cmd.load_root) begin
            n_sum = '0;
        end else if (r_sq_vld) begin
            n_sum = w_sum_ext[SUM_W] ? '1 : w_sum_ext[SUM_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else begin
            r_sum <= n_sum;
        end
    end

    assign w_trial = r_res + r_bit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bit <= '0;
        end else if (i_cmd.load_root) begin
            r_bit <= SQ_W'(1) << (SQ_W - 2);
        end else if (i_cmd.step_root) begin
            r_bit <= r_bit >> 2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_root) begin
            r_x   <= SQ_W'(r_sum);
            r_res <= '0;
        end else if (i_cmd.step_root) begin
            if (r_x >= w_trial) begin
                r_x   <= r_x - w_trial;
                r_res <= (r_res >> 1) + r_bit;
            end else begin
                r_res <= r_res >> 1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (i_cmd.emit) begin
            r_out_vld <= 1'b1;
        end else if (i_level_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            r_level <= LEVEL_W'(r_res);
        end
    end

    assign o_level_valid    = r_out_vld;
    assign o_residual_level = r_level;

    always_comb begin
        o_sts.in_valid   = i_bin_valid;
        o_sts.in_last    = w_last;
        o_sts.pipe_empty = !r_mag_vld && !r_sq_vld;
        o_sts.root_done  = (r_bit == '0);
        o_sts.out_free   = !r_out_vld || i_level_ready;
    end

endmodule
`default_nettype wire

// File: rtl/residual_vibration_level.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// residual_vibration_level
// Residual vibration level of one spectrum with the harmonic bins masked.
// ----------------------------------------------------------------------------
// Bins of one spectrum are taken one per clock cycle while the block is
// accumulating. The four harmonic centres (half, one, two and three times
// bin_ratio_q8 in Q8) that lie below the spectrum length mask every bin
// within half_width of them; the squares of the other bins are summed. After
// the last bin the block takes no bins while it drains the magnitude and
// square stages, loads the square root unit, which then resolves one result
// bit per cycle until all RES_W bits are known, sees the root done and loads
// the output register. The result waits in that register while the next
// spectrum streams in; if it is still not taken when the next root is ready,
// the block holds. A register write takes effect from the next bin taken.
// ----------------------------------------------------------------------------
module residual_vibration_level import rvl_pkg::*; #(
    parameter int MAX_BINS    = 4096,
    parameter int SAMPLE_BITS = 24
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    rvl_cfg_if.sink     i_cfg,
    rvl_bin_if.sink     i_bin,
    rvl_level_if.source o_level
);

    t_rvl_cmd w_cmd;
    t_rvl_sts w_sts;

    rvl_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_sts   (w_sts),
        .o_cmd   (w_cmd)
    );

    rvl_datapath #(
        .MAX_BINS    (MAX_BINS),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_datapath (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_valid      (i_cfg.valid),
        .i_cfg_index      (i_cfg.index),
        .i_cfg_data       (i_cfg.data),
        .o_cfg_ready      (i_cfg.ready),
        .i_bin_valid      (i_bin.valid),
        .i_bin_amplitude  (i_bin.bin_amplitude),
        .o_bin_ready      (i_bin.ready),
        .o_level_valid    (o_level.valid),
        .i_level_ready    (o_level.ready),
        .o_residual_level (o_level.residual_level),
        .i_cmd            (w_cmd),
        .o_sts            (w_sts)
    );

endmodule
`default_nettype wire
